// ----- hw/rtl/acp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types, character codes and helpers for the ASCII CAN command parser.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam logic [7:0] CR_CHAR     = 8'h0D;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UP_A    = 8'h41;
    localparam logic [7:0] CHR_UP_F    = 8'h46;
    localparam logic [7:0] CHR_LO_A    = 8'h61;
    localparam logic [7:0] CHR_LO_F    = 8'h66;
    localparam logic [7:0] UP_OFFSET   = 8'h37;
    localparam logic [7:0] LO_OFFSET   = 8'h57;

    localparam logic [7:0] LTR_STD_DATA = 8'h74;  // t
    localparam logic [7:0] LTR_EXT_DATA = 8'h54;  // T
    localparam logic [7:0] LTR_STD_RTR  = 8'h72;  // r
    localparam logic [7:0] LTR_EXT_RTR  = 8'h52;  // R
    localparam logic [7:0] LTR_STD_MASK = 8'h6B;  // k
    localparam logic [7:0] LTR_EXT_MASK = 8'h4B;  // K
    localparam logic [7:0] LTR_STD_FILT = 8'h6C;  // l
    localparam logic [7:0] LTR_EXT_FILT = 8'h4C;  // L

    localparam logic [28:0] STD_ID_MASK = 29'h0000_07FF;
    localparam logic [28:0] EXT_ID_MASK = 29'h1FFF_FFFF;
    localparam logic [4:0]  POS_MAX     = 5'd31;
    localparam logic [4:0]  STD_ID_LEN  = 5'd3;
    localparam logic [4:0]  EXT_ID_LEN  = 5'd8;

    typedef enum logic [2:0] {
        CODE_STD_DATA = 3'd0,
        CODE_EXT_DATA = 3'd1,
        CODE_STD_RTR  = 3'd2,
        CODE_EXT_RTR  = 3'd3,
        CODE_STD_MASK = 3'd4,
        CODE_EXT_MASK = 3'd5,
        CODE_STD_FILT = 3'd6,
        CODE_EXT_FILT = 3'd7
    } t_code;

    typedef enum logic [2:0] {
        KIND_STD_DATA  = 3'd0,
        KIND_EXT_DATA  = 3'd1,
        KIND_STD_RTR   = 3'd2,
        KIND_EXT_RTR   = 3'd3,
        KIND_SET_MASK  = 3'd4,
        KIND_SET_FILT  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_BAD_CMD = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  command_kind;
        logic [28:0] ident;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic [3:0]  slot;
        logic [1:0]  status;
    } t_result;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = {4'h0, c[3:0]};
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            d = c - CHR_ZERO;
        end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
            d = c - UP_OFFSET;
        end else if (c >= CHR_LO_A && c <= CHR_LO_F) begin
            d = c - LO_OFFSET;
        end
        return d[3:0];
    endfunction

endpackage

// ----- hw/rtl/acp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_byte_if / acp_result_if
// Valid/ready channels for received characters and parsed commands.
// ----------------------------------------------------------------------------
interface acp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface acp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command_kind;
    logic [28:0] ident;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic [3:0]  slot;
    logic [1:0]  status;

    modport source (output valid, output command_kind, output ident, output is_extended,
                    output is_remote, output byte_count, output payload, output slot,
                    output status, input ready);
    modport sink   (input valid, input command_kind, input ident, input is_extended,
                    input is_remote, input byte_count, input payload, input slot,
                    input status, output ready);
endinterface

// ----- hw/rtl/ascii_can_command_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_command_parser
// Parses CR-terminated ASCII CAN command lines (t T r R k K l L) one
// character per item and emits one parsed command per non-empty terminated line.
//
//   channel   dir  fields                                        item
//   i_cmd     in   in_byte                                       one character
//   o_res     out  command_kind ident is_extended is_remote       one command
//                  byte_count payload slot status
//
// One item per cycle sustained while o_res is not stalled; each character
// passes the input register, then the result register, before o_res.valid.
// The line state advances in the single pass between the two registers.
// A stalled result holds the result register; the input register still
// takes one more item, and ready drops only while both are full.
// Synchronous active-low reset clears the line state and both valid flags.
// ----------------------------------------------------------------------------
module ascii_can_command_parser #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    acp_byte_if.sink     i_cmd,
    acp_result_if.source o_res
);
    import acp_pkg::*;

    localparam int         DATA_W  = 8 * MAX_DATA_BYTES;
    localparam int         NIB_N   = 2 * MAX_DATA_BYTES;
    localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_out_vld, n_out_vld;
    t_result           r_out, n_out;

    logic [4:0]        r_pos, n_pos;
    t_code             r_code, n_code;
    logic [28:0]       r_ident, n_ident;
    logic [3:0]        r_len, n_len;
    logic [DATA_W-1:0] r_data, n_data;
    logic [3:0]        r_slot, n_slot;
    logic              r_bad, n_bad;

    logic              w_fire;
    logic [3:0]        w_nib;
    logic [4:0]        w_idlen;
    logic [5:0]        w_pos6;
    logic [5:0]        w_data_beg;
    logic [5:0]        w_data_end;
    logic [4:0]        w_k;
    logic [3:0]        w_nib_idx;
    logic              w_ok;

    assign w_fire      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_byte <= i_cmd.in_byte;
        end
    end

    assign w_nib      = hex_nibble(r_in_byte);
    assign w_idlen    = r_code[0] ? EXT_ID_LEN : STD_ID_LEN;
    assign w_pos6     = {1'b0, r_pos};
    assign w_data_beg = {1'b0, w_idlen} + 6'd2;
    assign w_data_end = w_data_beg + {1'b0, r_len, 1'b0};
    assign w_k        = r_pos - w_data_beg[4:0];
    assign w_nib_idx  = w_k[3:0] ^ 4'd1;

    always_comb begin
        priority if (r_code[2]) begin
            w_ok = (w_pos6 == w_data_beg);
        end else if (r_code[1]) begin
            w_ok = (w_pos6 >= w_data_beg);
        end else begin
            w_ok = (w_pos6 >= w_data_end);
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_code    = r_code;
        n_ident   = r_ident;
        n_len     = r_len;
        n_data    = r_data;
        n_slot    = r_slot;
        n_bad     = r_bad;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_res.ready;

        if (w_fire) begin
            if (r_in_byte != CR_CHAR) begin
                if (r_pos == 5'd0) begin
                    n_pos = 5'd1;
                    unique case (r_in_byte)
                        LTR_STD_DATA: n_code = CODE_STD_DATA;
                        LTR_EXT_DATA: n_code = CODE_EXT_DATA;
                        LTR_STD_RTR:  n_code = CODE_STD_RTR;
                        LTR_EXT_RTR:  n_code = CODE_EXT_RTR;
                        LTR_STD_MASK: n_code = CODE_STD_MASK;
                        LTR_EXT_MASK: n_code = CODE_EXT_MASK;
                        LTR_STD_FILT: n_code = CODE_STD_FILT;
                        LTR_EXT_FILT: n_code = CODE_EXT_FILT;
                        default: begin
                            n_code = CODE_STD_DATA;
                            n_bad  = 1'b1;
                        end
                    endcase
                end else begin
                    if (!r_bad) begin
                        if (!r_code[2]) begin
                            priority if (r_pos <= w_idlen) begin
                                n_ident = {r_ident[24:0], w_nib};
                            end else if (r_pos == w_idlen + 5'd1) begin
                                n_len = (w_nib > MAX_LEN) ? MAX_LEN : w_nib;
                            end else if (!r_code[1] && w_pos6 >= w_data_beg
                                         && w_pos6 < w_data_end) begin
                                for (int i = 0; i < NIB_N; i++) begin
                                    if (w_nib_idx == 4'(i)) begin
                                        n_data[4*i +: 4] = r_data[4*i +: 4] | w_nib;
                                    end
                                end
                            end else begin
                                n_data = r_data;
                            end
                        end else begin
                            priority if (r_pos == 5'd1) begin
                                n_slot = w_nib;
                            end else if (r_pos <= w_idlen + 5'd1) begin
                                n_ident = {r_ident[24:0], w_nib};
                            end else begin
                                n_ident = r_ident;
                            end
                        end
                    end
                    if (r_pos != POS_MAX) begin
                        n_pos = r_pos + 5'd1;
                    end
                end
            end else begin
                if (r_pos != 5'd0) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    if (r_bad) begin
                        n_out.status = ST_BAD_CMD;
                    end else begin
                        n_out.command_kind = r_code[2] ? (r_code[1] ? KIND_SET_FILT
                                                                    : KIND_SET_MASK)
                                                       : r_code;
                        n_out.is_extended  = r_code[0];
                        n_out.is_remote    = !r_code[2] && r_code[1];
                        if (w_ok) begin
                            n_out.ident  = r_ident & (r_code[0] ? EXT_ID_MASK : STD_ID_MASK);
                            n_out.status = ST_OK;
                            if (!r_code[2]) begin
                                n_out.byte_count = r_len;
                            end
                            if (!r_code[2] && !r_code[1]) begin
                                n_out.payload = 64'(r_data);
                            end
                            if (r_code[2]) begin
                                n_out.slot = r_slot;
                            end
                        end else begin
                            n_out.status = ST_LENGTH;
                        end
                    end
                end
                n_pos   = 5'd0;
                n_code  = CODE_STD_DATA;
                n_ident = '0;
                n_len   = '0;
                n_data  = '0;
                n_slot  = '0;
                n_bad   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pos     <= 5'd0;
            r_code    <= CODE_STD_DATA;
            r_ident   <= '0;
            r_len     <= '0;
            r_data    <= '0;
            r_slot    <= '0;
            r_bad     <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_pos     <= n_pos;
            r_code    <= n_code;
            r_ident   <= n_ident;
            r_len     <= n_len;
            r_data    <= n_data;
            r_slot    <= n_slot;
            r_bad     <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.command_kind = r_out.command_kind;
    assign o_res.ident        = r_out.ident;
    assign o_res.is_extended  = r_out.is_extended;
    assign o_res.is_remote    = r_out.is_remote;
    assign o_res.byte_count   = r_out.byte_count;
    assign o_res.payload      = r_out.payload;
    assign o_res.slot         = r_out.slot;
    assign o_res.status       = r_out.status;

`ifndef SYNTH
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_byte == CR_CHAR) |=> (r_pos == 5'd0 && !r_bad))
        else $error("line state not cleared after terminator");

    a_bad_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad |-> (r_code == CODE_STD_DATA && r_pos != 5'd0))
        else $error("unknown letter state inconsistent");

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_BAD_CMD) |->
        (r_out.ident == '0 && r_out.payload == '0 && r_out.command_kind == '0))
        else $error("unknown letter result carries data");

    a_std_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.is_extended) |-> (r_out.ident[28:11] == '0))
        else $error("standard identifier exceeds 11 bits");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.byte_count <= MAX_LEN && r_len <= MAX_LEN))
        else $error("length code above saturation limit");
`endif

endmodule

// ----- verif/tb_ascii_can_command_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_can_command_parser
// Self-checking bench for the ASCII CAN command line parser. Characters are
// sent one item per handshake; a line model predicts the parsed command for
// every carriage return, and each result item is checked field by field.
// Directed lines cover every command letter, field extremes, non-hex digits,
// short, long and trailing lines and unknown letters. Random traffic follows,
// mostly well-formed lines with random content plus broken lines and noise,
// under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_ascii_can_command_parser;
    import acp_pkg::*;

    localparam int MAX_BYTES = 8;
    localparam int CHARS_PER_PHASE = 100;
    localparam logic [7:0] LETTERS [8] = '{LTR_STD_DATA, LTR_EXT_DATA, LTR_STD_RTR,
        LTR_EXT_RTR, LTR_STD_MASK, LTR_EXT_MASK, LTR_STD_FILT, LTR_EXT_FILT};

    logic i_clk;
    logic i_rst_n;

    acp_byte_if   cmd_if ();
    acp_result_if res_if ();

    ascii_can_command_parser #(
        .MAX_DATA_BYTES(MAX_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    int src_idle_pct;
    int snk_stall_pct;
    int error_count;
    int cmds_checked;
    int chars_sent;

    t_result expected_cmds[$];

    // line model state
    logic [4:0]  line_pos;
    t_code       line_code;
    logic [28:0] id_acc;
    logic [3:0]  len_reg;
    logic [63:0] data_acc;
    logic [3:0]  slot_reg;
    logic        line_bad;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.in_byte = 8'h00;
        res_if.ready = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = {4'h0, c[3:0]};
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            d = c - CHR_ZERO;
        end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
            d = c - CHR_UP_A + 8'd10;
        end else if (c >= CHR_LO_A && c <= CHR_LO_F) begin
            d = c - CHR_LO_A + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic void clear_line_model();
        line_pos = '0;
        line_code = CODE_STD_DATA;
        id_acc = '0;
        len_reg = '0;
        data_acc = '0;
        slot_reg = '0;
        line_bad = 1'b0;
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        int p;
        int idlen;
        int k;
        int sh;
        logic [3:0] nib;
        p = line_pos;
        idlen = line_code[0] ? EXT_ID_LEN : STD_ID_LEN;
        nib = nibble_of(c);
        if (line_bad) return;
        if (line_code < CODE_STD_MASK) begin
            if (p >= 1 && p <= idlen) begin
                id_acc = {id_acc[24:0], nib};
            end else if (p == idlen + 1) begin
                len_reg = (nib > MAX_BYTES) ? 4'(MAX_BYTES) : nib;
            end else if (line_code < CODE_STD_RTR && p >= idlen + 2 &&
                         p < idlen + 2 + 2 * len_reg) begin
                k = p - (idlen + 2);
                sh = 8 * (k >> 1) + ((k % 2 == 0) ? 4 : 0);
                data_acc |= {60'h0, nib} << sh;
            end
        end else begin
            if (p == 1) begin
                slot_reg = nib;
            end else if (p >= 2 && p <= idlen + 1) begin
                id_acc = {id_acc[24:0], nib};
            end
        end
    endfunction

    function automatic void close_line();
        t_result r;
        int p;
        int idlen;
        logic ok;
        r = '0;
        p = line_pos;
        idlen = line_code[0] ? EXT_ID_LEN : STD_ID_LEN;
        if (line_bad) begin
            r.status = ST_BAD_CMD;
        end else begin
            if (line_code < CODE_STD_RTR) begin
                ok = (p >= idlen + 2) && (p >= idlen + 2 + 2 * len_reg);
            end else if (line_code < CODE_STD_MASK) begin
                ok = (p >= idlen + 2);
            end else begin
                ok = (p == idlen + 2);
            end
            if (line_code[2]) begin
                r.command_kind = line_code[1] ? KIND_SET_FILT : KIND_SET_MASK;
            end else begin
                r.command_kind = line_code;
            end
            r.is_extended = line_code[0];
            r.is_remote = (line_code == CODE_STD_RTR || line_code == CODE_EXT_RTR);
            if (ok) begin
                r.ident = id_acc & (line_code[0] ? EXT_ID_MASK : STD_ID_MASK);
                if (line_code < CODE_STD_MASK) r.byte_count = len_reg;
                if (line_code < CODE_STD_RTR) r.payload = data_acc;
                if (line_code >= CODE_STD_MASK) r.slot = slot_reg;
                r.status = ST_OK;
            end else begin
                r.status = ST_LENGTH;
            end
        end
        expected_cmds.push_back(r);
        clear_line_model();
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        if (c != CR_CHAR) begin
            if (line_pos == 0) begin
                case (c)
                    LTR_STD_DATA: line_code = CODE_STD_DATA;
                    LTR_EXT_DATA: line_code = CODE_EXT_DATA;
                    LTR_STD_RTR:  line_code = CODE_STD_RTR;
                    LTR_EXT_RTR:  line_code = CODE_EXT_RTR;
                    LTR_STD_MASK: line_code = CODE_STD_MASK;
                    LTR_EXT_MASK: line_code = CODE_EXT_MASK;
                    LTR_STD_FILT: line_code = CODE_STD_FILT;
                    LTR_EXT_FILT: line_code = CODE_EXT_FILT;
                    default: begin
                        line_bad = 1'b1;
                        line_code = CODE_STD_DATA;
                    end
                endcase
                line_pos = 5'd1;
            end else begin
                absorb_char(c);
                if (line_pos < POS_MAX) line_pos = line_pos + 5'd1;
            end
        end else if (line_pos == 0) begin
            clear_line_model();
        end else begin
            close_line();
        end
    endfunction

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.in_byte <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict_char(c);
        chars_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CR_CHAR);
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[i]) send_char(q[i]);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10) begin
                $display("command %0d: %s expected %0h, got %0h",
                         cmds_checked, name, want, got);
            end
        end
    endtask

    task automatic check_command(input t_result got);
        t_result want;
        if (expected_cmds.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
                $display("unexpected command: kind %0d ident %0h status %0d",
                         got.command_kind, got.ident, got.status);
            end
            return;
        end
        want = expected_cmds.pop_front();
        compare_field("command_kind", want.command_kind, got.command_kind);
        compare_field("ident", want.ident, got.ident);
        compare_field("is_extended", want.is_extended, got.is_extended);
        compare_field("is_remote", want.is_remote, got.is_remote);
        compare_field("byte_count", want.byte_count, got.byte_count);
        compare_field("payload", want.payload, got.payload);
        compare_field("slot", want.slot, got.slot);
        compare_field("status", want.status, got.status);
        cmds_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            check_command({res_if.command_kind, res_if.ident, res_if.is_extended,
                           res_if.is_remote, res_if.byte_count, res_if.payload,
                           res_if.slot, res_if.status});
        end
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic logic [7:0] any_non_cr();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CR_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] unknown_letter();
        logic [7:0] c;
        do c = any_non_cr(); while (c inside {LETTERS});
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CHR_ZERO + {4'h0, nib};
        end else if ($urandom_range(1)) begin
            c = CHR_UP_A + {4'h0, nib} - 8'd10;
        end else begin
            c = CHR_LO_A + {4'h0, nib} - 8'd10;
        end
        if ($urandom_range(99) < 6) c = any_non_cr();
        return c;
    endfunction

    task automatic test_data_frames();
        send_line("t1238001122334455667788");
        send_line("TFFFFFFFF8FFFFFFFFFFFFFFFF");
        send_line("t0000");
        send_line("t7ff1aB");
        send_line("T000000003c0FfE");
        send_line("t123F0102030405060708");
        send_line("t1G2Zxyz12345678");
        send_line("t1231AAtrailing");
    endtask

    task automatic test_remote_frames();
        send_line("r7FF0");
        send_line("R1FFFFFFF8");
        send_line("r0009");
        send_line("R12345678fextra");
    endtask

    task automatic test_mask_filter();
        send_line("k0123");
        send_line("KF1FFFFFFF");
        send_line("lA7ff");
        send_line("L0abcdef01");
        send_line("kZ!@#");
    endtask

    task automatic test_malformed_lines();
        send_char(CR_CHAR);
        send_line("t1234AB");
        send_line("T123");
        send_line("t");
        send_line("r12");
        send_line("k012");
        send_line("K01234567890");
        send_line("x123");
        send_char(8'h00);
        send_char(CR_CHAR);
        send_char(8'hFF);
        send_line("t1238");
        send_line("t1230qwertyuiopasdfghjklzxcvbnmqwertyuiop");
        send_line("k0123456789abcdefghijklmnopqrstuvwxyz");
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        logic [7:0] q[$];
        int stop_at;
        int mode;
        int code;
        int idlen;
        int len;
        int n;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = chars_sent + CHARS_PER_PHASE;
        while (chars_sent < stop_at) begin
            q.delete();
            mode = $urandom_range(99);
            code = $urandom_range(7);
            idlen = code[0] ? EXT_ID_LEN : STD_ID_LEN;
            if (mode < 87) begin
                q.push_back(LETTERS[code]);
                if (code >= CODE_STD_MASK) q.push_back(hex_char(4'($urandom_range(15))));
                for (int i = 0; i < idlen; i++) q.push_back(hex_char(4'($urandom_range(15))));
                if (code < CODE_STD_MASK) begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(8);
                    q.push_back(hex_char(4'(len)));
                    if (code < CODE_STD_RTR) begin
                        n = 2 * ((len > MAX_BYTES) ? MAX_BYTES : len);
                        for (int i = 0; i < n; i++)
                            q.push_back(hex_char(4'($urandom_range(15))));
                    end
                end
                if (mode >= 70 && mode < 80) begin
                    n = $urandom_range(q.size() - 1);
                    while (q.size() > n) void'(q.pop_back());
                end else if (mode >= 80) begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) q.push_back(any_non_cr());
                end
                q.push_back(CR_CHAR);
            end else if (mode < 93) begin
                q.push_back(unknown_letter());
                n = $urandom_range(0, 12);
                for (int i = 0; i < n; i++) q.push_back(any_non_cr());
                q.push_back(CR_CHAR);
            end else if (mode < 96) begin
                q.push_back(CR_CHAR);
            end else begin
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
            end
            send_bytes(q);
        end
        send_char(CR_CHAR);
    endtask

    initial begin
        error_count = 0;
        cmds_checked = 0;
        chars_sent = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        clear_line_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_data_frames();
        test_remote_frames();
        test_mask_filter();
        test_malformed_lines();
        test_random_traffic(0, 0);
        test_random_traffic(45, 0);
        test_random_traffic(0, 45);
        test_random_traffic(26, 26);
        cmd_if.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
